// ===== src/dhcprp_pkg.sv =====
// ----------------------------------------------------------------------------
// dhcprp_pkg
// Shared types and constants of the DHCP reply parser: header offsets,
// option codes, configuration register indexes and the option walk phases.
// ----------------------------------------------------------------------------
`default_nettype none

package dhcprp_pkg;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 48;

	localparam logic [CFG_INDEX_W-1:0] REG_CLIENT_MAC     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TRANSACTION_ID = 2'd1;

	localparam logic [47:0] CLIENT_MAC_RESET     = 48'h0;
	localparam logic [31:0] TRANSACTION_ID_RESET = 32'hADDE_1223;

	localparam int unsigned POS_OP         = 0;
	localparam int unsigned POS_XID_FIRST  = 4;
	localparam int unsigned POS_XID_LAST   = 7;
	localparam int unsigned POS_YIP_FIRST  = 16;
	localparam int unsigned POS_YIP_LAST   = 19;
	localparam int unsigned POS_MAC_FIRST  = 28;
	localparam int unsigned POS_MAC_LAST   = 33;
	localparam int unsigned POS_OPT_BASE   = 240;

	localparam logic [7:0] OP_BOOTREPLY = 8'd2;

	localparam logic [7:0] OPT_PAD      = 8'd0;
	localparam logic [7:0] OPT_SUBNET   = 8'd1;
	localparam logic [7:0] OPT_ROUTER   = 8'd3;
	localparam logic [7:0] OPT_DNS      = 8'd6;
	localparam logic [7:0] OPT_LEASE    = 8'd51;
	localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
	localparam logic [7:0] OPT_SERVER   = 8'd54;
	localparam logic [7:0] OPT_END      = 8'd255;

	localparam int unsigned KEPT_SLOTS = 6;
	localparam logic [2:0] SLOT_YIP    = 3'd0;
	localparam logic [2:0] SLOT_SUBNET = 3'd1;
	localparam logic [2:0] SLOT_ROUTER = 3'd2;
	localparam logic [2:0] SLOT_DNS    = 3'd3;
	localparam logic [2:0] SLOT_SERVER = 3'd4;
	localparam logic [2:0] SLOT_LEASE  = 3'd5;

	localparam logic [2:0] CAPTURE_FULL = 3'd4;

	typedef enum logic [2:0] {
		PH_CODE  = 3'b001,
		PH_LEN   = 3'b010,
		PH_VALUE = 3'b100
	} tlv_phase_t;

	typedef logic [31:0] word_t;

endpackage

`default_nettype wire

// ===== src/dhcp_reply_parser.sv =====
// ----------------------------------------------------------------------------
// dhcp_reply_parser
// Byte-serial DHCP reply header check and option extractor.
// ----------------------------------------------------------------------------
// Bytes of one reply enter one per cycle from offset zero; each byte is held
// in an input register and then updates the header check, the option walk
// and the stored addresses, so the block sustains one byte per clock. The
// byte marked last_byte produces one result, passing from the input register
// to an output register: the accept verdict, the message type of this packet
// and the six stored values, which persist across packets and are reported
// in rejects too. Only a last byte waiting behind an unread result stalls
// the input; other bytes keep flowing while a result is held.
// ----------------------------------------------------------------------------
`default_nettype none

module dhcp_reply_parser #(
	parameter int unsigned MAX_PACKET_BYTES = 1500
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [dhcprp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [dhcprp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [7:0]                         data_byte,
	input  wire logic                               last_byte,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    accepted,
	output logic [7:0]                              message_type,
	output logic [31:0]                             your_ip,
	output logic [31:0]                             subnet_mask,
	output logic [31:0]                             router_addr,
	output logic [31:0]                             dns_addr,
	output logic [31:0]                             server_ident,
	output logic [31:0]                             lease_seconds
);

	import dhcprp_pkg::*;

	localparam int unsigned PosW = $clog2(MAX_PACKET_BYTES + 1);
	localparam logic [PosW-1:0] PosMax = PosW'(MAX_PACKET_BYTES);

	logic [47:0] client_mac_q;
	logic [31:0] transaction_id_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        advance;

	logic [PosW-1:0] pos_q, pos_d;
	logic            match_q, match_d;
	word_t           pend_yip_q, pend_yip_d;
	tlv_phase_t      phase_q, phase_d;
	logic [7:0]      code_q, code_d;
	logic [7:0]      skip_q, skip_d;
	logic [2:0]      cap_cnt_q, cap_cnt_d;
	word_t           cap_shift_q, cap_shift_d;
	logic            end_q, end_d;
	logic [7:0]      type_q, type_d;
	word_t           kept_q [KEPT_SLOTS];
	word_t           kept_d [KEPT_SLOTS];

	logic [PosW-1:0] mac_off;
	logic [7:0]      xid_byte, mac_byte;
	logic            acc;
	logic            store_en;
	logic [2:0]      store_slot;
	logic            slot_hit;

	logic            out_valid_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			client_mac_q     <= CLIENT_MAC_RESET;
			transaction_id_q <= TRANSACTION_ID_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CLIENT_MAC:     client_mac_q <= cfg_data;
				REG_TRANSACTION_ID: transaction_id_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// input register: hold a last byte while the previous result waits
	assign advance  = valid_s1 && !(last_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_comb begin
		unique case (pos_q[1:0])
			2'd0:    xid_byte = transaction_id_q[31:24];
			2'd1:    xid_byte = transaction_id_q[23:16];
			2'd2:    xid_byte = transaction_id_q[15:8];
			default: xid_byte = transaction_id_q[7:0];
		endcase
		mac_off = pos_q - PosW'(POS_MAC_FIRST);
		unique case (mac_off[2:0])
			3'd0:    mac_byte = client_mac_q[47:40];
			3'd1:    mac_byte = client_mac_q[39:32];
			3'd2:    mac_byte = client_mac_q[31:24];
			3'd3:    mac_byte = client_mac_q[23:16];
			3'd4:    mac_byte = client_mac_q[15:8];
			3'd5:    mac_byte = client_mac_q[7:0];
			default: mac_byte = 8'h00;
		endcase
	end

	always_comb begin
		unique case (code_q)
			OPT_SUBNET: begin store_slot = SLOT_SUBNET; slot_hit = 1'b1; end
			OPT_ROUTER: begin store_slot = SLOT_ROUTER; slot_hit = 1'b1; end
			OPT_DNS:    begin store_slot = SLOT_DNS;    slot_hit = 1'b1; end
			OPT_SERVER: begin store_slot = SLOT_SERVER; slot_hit = 1'b1; end
			OPT_LEASE:  begin store_slot = SLOT_LEASE;  slot_hit = 1'b1; end
			default:    begin store_slot = SLOT_YIP;    slot_hit = 1'b0; end
		endcase
	end

	// per-byte update
	always_comb begin
		pos_d       = pos_q;
		match_d     = match_q;
		pend_yip_d  = pend_yip_q;
		phase_d     = phase_q;
		code_d      = code_q;
		skip_d      = skip_q;
		cap_cnt_d   = cap_cnt_q;
		cap_shift_d = cap_shift_q;
		end_d       = end_q;
		type_d      = type_q;
		store_en    = 1'b0;
		for (int i = 0; i < KEPT_SLOTS; i++) begin
			kept_d[i] = kept_q[i];
		end

		if (pos_q < PosMax) begin
			pos_d = pos_q + PosW'(1);
			if (pos_q == PosW'(POS_OP)) begin
				if (byte_s1 != OP_BOOTREPLY) match_d = 1'b0;
			end else if (pos_q >= PosW'(POS_XID_FIRST) && pos_q <= PosW'(POS_XID_LAST)) begin
				if (byte_s1 != xid_byte) match_d = 1'b0;
			end else if (pos_q >= PosW'(POS_YIP_FIRST) && pos_q <= PosW'(POS_YIP_LAST)) begin
				pend_yip_d = {pend_yip_q[23:0], byte_s1};
			end else if (pos_q >= PosW'(POS_MAC_FIRST) && pos_q <= PosW'(POS_MAC_LAST)) begin
				if (byte_s1 != mac_byte) match_d = 1'b0;
			end else if (pos_q >= PosW'(POS_OPT_BASE) && match_q && !end_q) begin
				unique case (phase_q)
					PH_CODE: begin
						if (byte_s1 == OPT_END) begin
							end_d = 1'b1;
						end else if (byte_s1 != OPT_PAD) begin
							code_d  = byte_s1;
							phase_d = PH_LEN;
						end
					end
					PH_LEN: begin
						skip_d      = byte_s1;
						cap_cnt_d   = 3'd0;
						cap_shift_d = '0;
						phase_d     = (byte_s1 == 8'd0) ? PH_CODE : PH_VALUE;
					end
					PH_VALUE: begin
						if (code_q == OPT_MSG_TYPE && cap_cnt_q == 3'd0) type_d = byte_s1;
						if (cap_cnt_q < CAPTURE_FULL) begin
							cap_shift_d = {cap_shift_q[23:0], byte_s1};
							cap_cnt_d   = cap_cnt_q + 3'd1;
							store_en    = (cap_cnt_d == CAPTURE_FULL) && slot_hit;
						end
						skip_d = skip_q - 8'd1;
						if (skip_d == 8'd0) phase_d = PH_CODE;
					end
					default: phase_d = PH_CODE;
				endcase
			end
		end

		if (store_en) kept_d[store_slot] = cap_shift_d;

		acc = match_d && (pos_q >= PosW'(POS_MAC_LAST));
		if (last_s1 && acc) kept_d[SLOT_YIP] = pend_yip_d;
	end

	// packet state: clear on the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			match_q     <= 1'b1;
			pend_yip_q  <= '0;
			phase_q     <= PH_CODE;
			code_q      <= '0;
			skip_q      <= '0;
			cap_cnt_q   <= '0;
			cap_shift_q <= '0;
			end_q       <= 1'b0;
			type_q      <= '0;
			for (int i = 0; i < KEPT_SLOTS; i++) begin
				kept_q[i] <= '0;
			end
		end else if (advance) begin
			for (int i = 0; i < KEPT_SLOTS; i++) begin
				kept_q[i] <= kept_d[i];
			end
			if (last_s1) begin
				pos_q       <= '0;
				match_q     <= 1'b1;
				pend_yip_q  <= '0;
				phase_q     <= PH_CODE;
				code_q      <= '0;
				skip_q      <= '0;
				cap_cnt_q   <= '0;
				cap_shift_q <= '0;
				end_q       <= 1'b0;
				type_q      <= '0;
			end else begin
				pos_q       <= pos_d;
				match_q     <= match_d;
				pend_yip_q  <= pend_yip_d;
				phase_q     <= phase_d;
				code_q      <= code_d;
				skip_q      <= skip_d;
				cap_cnt_q   <= cap_cnt_d;
				cap_shift_q <= cap_shift_d;
				end_q       <= end_d;
				type_q      <= type_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			accepted      <= acc;
			message_type  <= acc ? type_d : 8'd0;
			your_ip       <= kept_d[SLOT_YIP];
			subnet_mask   <= kept_d[SLOT_SUBNET];
			router_addr   <= kept_d[SLOT_ROUTER];
			dns_addr      <= kept_d[SLOT_DNS];
			server_ident  <= kept_d[SLOT_SERVER];
			lease_seconds <= kept_d[SLOT_LEASE];
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire
